// ----- hdl/cbau_pkg.sv -----
// cbau_pkg: shared types and constants for the clockwise bearing angle unit
// no dependencies; imported by every cbau module

package cbau_pkg;

	// guard bits below the coordinate magnitude in the cordic datapath
	localparam int GUARD_BITS = 24;

	// internal angles are 32-bit fractions of a turn
	localparam int TURN_BITS = 32;
	localparam logic [TURN_BITS-1:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [TURN_BITS-1:0] TURN_QUARTER = 32'h4000_0000;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [TURN_BITS-1:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	// quadrant and special-case flags that ride along the pipeline
	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic a_neg;
		logic b_neg;
		logic screen;
	} quad_t;

endpackage

// ----- hdl/cbau_fold.sv -----
// cbau_fold: input stage, folds the offset vector into magnitudes and quadrant flags
// depends on cbau_pkg

module cbau_fold import cbau_pkg::*; #(
	parameter int COORD_WIDTH  = 16,
	parameter int CORDIC_WIDTH = 42
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic signed [COORD_WIDTH-1:0]  x_offset,
	input  logic signed [COORD_WIDTH-1:0]  y_offset,
	input  logic                           mode,
	output logic                           out_vld,
	output logic signed [CORDIC_WIDTH-1:0] out_x,
	output logic signed [CORDIC_WIDTH-1:0] out_y,
	output quad_t                          out_flags
);

	localparam int PAD = CORDIC_WIDTH - COORD_WIDTH - GUARD_BITS;

	logic signed [COORD_WIDTH:0]   a_ext;
	logic signed [COORD_WIDTH:0]   y_ext;
	logic signed [COORD_WIDTH:0]   b_ext;
	logic signed [COORD_WIDTH:0]   a_neg_val;
	logic signed [COORD_WIDTH:0]   b_neg_val;
	logic        [COORD_WIDTH-1:0] ma;
	logic        [COORD_WIDTH-1:0] mb;
	quad_t                         flags_d;

	logic                           vld_s1;
	logic signed [CORDIC_WIDTH-1:0] x_s1;
	logic signed [CORDIC_WIDTH-1:0] y_s1;
	quad_t                          flags_s1;

	always_comb begin
		a_ext     = {x_offset[COORD_WIDTH-1], x_offset};
		y_ext     = {y_offset[COORD_WIDTH-1], y_offset};
		b_ext     = mode ? y_ext : -y_ext;
		a_neg_val = -a_ext;
		b_neg_val = -b_ext;
		ma        = a_ext[COORD_WIDTH] ? a_neg_val[COORD_WIDTH-1:0] : a_ext[COORD_WIDTH-1:0];
		mb        = b_ext[COORD_WIDTH] ? b_neg_val[COORD_WIDTH-1:0] : b_ext[COORD_WIDTH-1:0];
		flags_d.a_zero = (x_offset == '0);
		flags_d.b_zero = (y_offset == '0);
		flags_d.a_neg  = x_offset[COORD_WIDTH-1];
		flags_d.b_neg  = b_ext[COORD_WIDTH];
		flags_d.screen = mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	// abscissa is |b|, ordinate is |a|
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= signed'({{PAD{1'b0}}, mb, {GUARD_BITS{1'b0}}});
			y_s1     <= signed'({{PAD{1'b0}}, ma, {GUARD_BITS{1'b0}}});
			flags_s1 <= flags_d;
		end
	end

	assign out_vld   = vld_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_flags = flags_s1;

endmodule

// ----- hdl/cbau_cordic.sv -----
// cbau_cordic: vectoring cordic, one micro-rotation per pipeline stage
// depends on cbau_pkg

module cbau_cordic import cbau_pkg::*; #(
	parameter int CORDIC_WIDTH = 42,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic signed [CORDIC_WIDTH-1:0] in_x,
	input  logic signed [CORDIC_WIDTH-1:0] in_y,
	input  quad_t                          in_flags,
	output logic                           out_vld,
	output logic        [TURN_BITS-1:0]    out_z,
	output quad_t                          out_flags
);

	logic                           vld_s   [CORDIC_STEPS];
	logic signed [CORDIC_WIDTH-1:0] x_s     [CORDIC_STEPS];
	logic signed [CORDIC_WIDTH-1:0] y_s     [CORDIC_STEPS];
	logic        [TURN_BITS-1:0]    z_s     [CORDIC_STEPS];
	quad_t                          flags_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic                           vp;
		logic signed [CORDIC_WIDTH-1:0] xp;
		logic signed [CORDIC_WIDTH-1:0] yp;
		logic        [TURN_BITS-1:0]    zp;
		quad_t                          fp;
		logic signed [CORDIC_WIDTH-1:0] dx;
		logic signed [CORDIC_WIDTH-1:0] dy;

		if (i == 0) begin : g_first
			assign vp = in_vld;
			assign xp = in_x;
			assign yp = in_y;
			assign zp = '0;
			assign fp = in_flags;
		end else begin : g_next
			assign vp = vld_s[i-1];
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign fp = flags_s[i-1];
		end

		assign dx = yp >>> i;
		assign dy = xp >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flags_s[i] <= fp;
				if (!yp[CORDIC_WIDTH-1]) begin
					x_s[i] <= xp + dx;
					y_s[i] <= yp - dy;
					z_s[i] <= zp + ATAN_TAB[i];
				end else begin
					x_s[i] <= xp - dx;
					y_s[i] <= yp + dy;
					z_s[i] <= zp - ATAN_TAB[i];
				end
			end
		end
	end

	assign out_vld   = vld_s[CORDIC_STEPS-1];
	assign out_z     = z_s[CORDIC_STEPS-1];
	assign out_flags = flags_s[CORDIC_STEPS-1];

endmodule

// ----- hdl/cbau_resolve.sv -----
// cbau_resolve: quadrant unfold, rounding, output register and skid stage
// depends on cbau_pkg

module cbau_resolve import cbau_pkg::*; #(
	parameter int ANGLE_WIDTH = 16,
	parameter int OUT_W       = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  logic [TURN_BITS-1:0]   in_z,
	input  quad_t                  in_flags,
	output logic                   en,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata
);

	localparam int SHIFT = TURN_BITS - ANGLE_WIDTH;
	localparam logic [TURN_BITS-1:0] RND = TURN_BITS'((33'd1 << SHIFT) >> 1);

	logic [TURN_BITS-1:0]   phi;
	logic [TURN_BITS-1:0]   base;
	logic                   neg;
	logic [TURN_BITS-1:0]   sum;
	logic [ANGLE_WIDTH-1:0] bearing_d;
	logic                   stall;

	logic                   out_vld_q;
	logic [ANGLE_WIDTH-1:0] out_data_q;
	logic                   skid_vld_q;
	logic [ANGLE_WIDTH-1:0] skid_data_q;

	// bearing = base +/- phi, rounded half up, wraps modulo one turn
	always_comb begin
		if (in_flags.a_zero) begin
			phi = '0;
		end else if (in_flags.b_zero) begin
			phi = TURN_QUARTER;
		end else begin
			phi = in_z;
		end
		if (in_flags.a_zero && in_flags.b_zero) begin
			base = in_flags.screen ? TURN_HALF : '0;
			neg  = 1'b0;
		end else begin
			base = in_flags.b_neg ? '0 : TURN_HALF;
			neg  = (in_flags.a_neg == in_flags.b_neg);
		end
		sum       = base + RND + (neg ? ~phi : phi) + TURN_BITS'(neg);
		bearing_d = sum[TURN_BITS-1:SHIFT];
	end

	assign stall = out_vld_q && !m_axis_tready;
	assign en    = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_axis_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (stall) begin
			skid_vld_q <= in_vld;
		end else begin
			out_vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
			end
		end else if (stall) begin
			skid_data_q <= bearing_d;
		end else begin
			out_data_q <= bearing_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

`ifndef NO_ASSERTIONS
	// the skid stage only holds data behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid stage valid without output valid");

	// the skid stage fills only when the output was stalled
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
		else $error("skid stage filled without a stalled output");

	// a drained skid entry becomes the next output transfer
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && m_axis_tready |=> out_vld_q && (out_data_q == $past(skid_data_q)))
		else $error("skid entry lost on drain");
`endif

endmodule

// ----- hdl/clockwise_bearing_angle_unit.sv -----
// clockwise_bearing_angle_unit: clockwise bearing from up of a signed offset vector
// an input transfer passes the fold register, the cordic stage registers and the output register before output valid
// throughput: one vector per cycle while s_axis_tready is high, set by one cordic micro-rotation per pipeline stage
// a two-entry output register and skid stage decouple s_axis_tready from m_axis_tready
// arst_n clears all valid bits at once; data registers are not reset
// depends on cbau_pkg, cbau_fold, cbau_cordic, cbau_resolve

module clockwise_bearing_angle_unit import cbau_pkg::*; #(
	parameter int COORD_WIDTH  = 16,
	parameter int ANGLE_WIDTH  = 16,
	parameter int CORDIC_STEPS = 16,
	localparam int IN_W  = ((2 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((ANGLE_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // x_offset, y_offset, zero pad
	input  logic             s_axis_tuser,  // mode
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // bearing, zero pad
);

	localparam int CORDIC_WIDTH = COORD_WIDTH + GUARD_BITS + 2;

	logic                           en;
	logic signed [COORD_WIDTH-1:0]  x_offset;
	logic signed [COORD_WIDTH-1:0]  y_offset;

	logic                           fold_vld;
	logic signed [CORDIC_WIDTH-1:0] fold_x;
	logic signed [CORDIC_WIDTH-1:0] fold_y;
	quad_t                          fold_flags;

	logic                           cordic_vld;
	logic        [TURN_BITS-1:0]    cordic_z;
	quad_t                          cordic_flags;

	assign x_offset      = signed'(s_axis_tdata[COORD_WIDTH-1:0]);
	assign y_offset      = signed'(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
	assign s_axis_tready = en;

	cbau_fold #(
		.COORD_WIDTH  (COORD_WIDTH),
		.CORDIC_WIDTH (CORDIC_WIDTH)
	) u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_axis_tvalid),
		.x_offset  (x_offset),
		.y_offset  (y_offset),
		.mode      (s_axis_tuser),
		.out_vld   (fold_vld),
		.out_x     (fold_x),
		.out_y     (fold_y),
		.out_flags (fold_flags)
	);

	cbau_cordic #(
		.CORDIC_WIDTH (CORDIC_WIDTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (fold_vld),
		.in_x      (fold_x),
		.in_y      (fold_y),
		.in_flags  (fold_flags),
		.out_vld   (cordic_vld),
		.out_z     (cordic_z),
		.out_flags (cordic_flags)
	);

	cbau_resolve #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.OUT_W       (OUT_W)
	) u_resolve (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (cordic_vld),
		.in_z          (cordic_z),
		.in_flags      (cordic_flags),
		.en            (en),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- tb/sv/tb_clockwise_bearing_angle_unit.sv -----
// tb_clockwise_bearing_angle_unit: stream testbench for the clockwise bearing angle unit
// predicts each bearing with a fixed-point vectoring cordic and checks results in order
// depends on cbau_pkg and clockwise_bearing_angle_unit
`timescale 1ns / 100ps

module tb_clockwise_bearing_angle_unit;

	localparam int ROTATIONS = 16;
	localparam int GUARD = 24;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 270;

	// atan(2^-i) in 2^-32 turn units
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	class bearing_scoreboard;
		logic [15:0] pending_bearings[$];
		int mismatches = 0;
		int vectors_seen = 0;
		int results_seen = 0;

		// angle of (mx, my) in the first quadrant, both nonnegative
		function logic [31:0] fold_turn(longint mx, longint my);
			longint cx, cy, sx, sy;
			logic [31:0] z;
			z = '0;
			if (my == 0)
				return '0;
			if (mx == 0)
				return QUARTER_TURN;
			cx = mx <<< GUARD;
			cy = my <<< GUARD;
			for (int i = 0; i < ROTATIONS; i++) begin
				sx = cy >>> i;
				sy = cx >>> i;
				if (cy >= 0) begin
					cx = cx + sx;
					cy = cy - sy;
					z = z + ATAN_TURNS[i];
				end else begin
					cx = cx - sx;
					cy = cy + sy;
					z = z - ATAN_TURNS[i];
				end
			end
			return z;
		endfunction

		function logic [15:0] predict_bearing(logic signed [15:0] x, logic signed [15:0] y,
				logic screen);
			longint a, b, ma, mb;
			logic [31:0] phi, theta, bear;
			logic [32:0] rounded;
			a = longint'(x);
			b = screen ? longint'(y) : -longint'(y);
			if (a == 0 && b == 0) begin
				theta = screen ? 32'd0 : HALF_TURN;
			end else begin
				ma = (a < 0) ? -a : a;
				mb = (b < 0) ? -b : b;
				phi = fold_turn(mb, ma);
				if (b >= 0)
					theta = (a >= 0) ? phi : (32'd0 - phi);
				else
					theta = (a >= 0) ? (HALF_TURN - phi) : (phi - HALF_TURN);
			end
			bear = HALF_TURN - theta;
			rounded = {1'b0, bear} + 33'h0_0000_8000;
			return rounded[31:16];
		endfunction

		function void note_input(logic signed [15:0] x, logic signed [15:0] y, logic screen);
			pending_bearings.push_back(predict_bearing(x, y, screen));
			vectors_seen++;
		endfunction

		function void check_result(logic [15:0] got);
			logic [15:0] want;
			results_seen++;
			if (pending_bearings.size() == 0) begin
				$error("bearing: unexpected result, expected none, got %0d", got);
				mismatches++;
			end else begin
				want = pending_bearings.pop_front();
				if (got !== want) begin
					$error("bearing: expected %0d, got %0d", want, got);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // x_offset, y_offset
	logic s_axis_tuser = 1'b0;       // mode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // bearing

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int cycle_count = 0;
	bearing_scoreboard sb = new();

	clockwise_bearing_angle_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_clockwise_bearing_angle_unit: FAIL");
			$finish;
		end
	end

	task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic screen);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		s_axis_tuser <= screen;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(x, y, screen);
	endtask

	task automatic send_random(input int count);
		logic signed [15:0] x, y;
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 3);
			x = 16'($urandom);
			y = 16'($urandom);
			case (kind)
				1: begin
					// tiny vectors, many folds hit the axis cases
					x = 16'(int'($urandom_range(0, 8)) - 4);
					y = 16'(int'($urandom_range(0, 8)) - 4);
				end
				2: begin
					if ($urandom_range(0, 1))
						x = '0;
					else
						y = '0;
				end
				3: begin
					// near the diagonals
					y = ($urandom_range(0, 1) ? x : -x) + 16'(int'($urandom_range(0, 6)) - 3);
				end
				default: begin
				end
			endcase
			send_vector(x, y, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int src_phase [4];
		int sink_phase [4];
		src_phase = '{0, 86, 0, 24};
		sink_phase = '{0, 0, 86, 24};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// zero vector, axes, extremes and each quadrant in both modes
		send_vector(0, 0, 0);
		send_vector(0, 0, 1);
		send_vector(0, 1, 0);
		send_vector(0, -1, 1);
		send_vector(1, 0, 0);
		send_vector(-1, 0, 1);
		send_vector(0, 32767, 0);
		send_vector(32767, 0, 1);
		send_vector(-32768, 0, 0);
		send_vector(0, -32768, 1);
		send_vector(32767, 32767, 0);
		send_vector(32767, 32767, 1);
		send_vector(-32768, -32768, 0);
		send_vector(-32768, -32768, 1);
		send_vector(32767, -32768, 0);
		send_vector(-32768, 32767, 1);
		send_vector(1, 1, 0);
		send_vector(-1, -1, 1);
		send_vector(-1, 1, 0);
		send_vector(1, -1, 1);
		send_vector(3, -7, 0);
		send_vector(-12345, 23456, 1);

		for (int p = 0; p < 4; p++) begin
			src_idle_pct = src_phase[p];
			sink_stall_pct = sink_phase[p];
			send_random(RANDOM_PER_PHASE);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (sb.pending_bearings.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("checked %0d bearings from %0d vectors, both axis modes, four handshake mixes",
			sb.results_seen, sb.vectors_seen);
		if (sb.mismatches == 0 && sb.pending_bearings.size() == 0)
			$display("tb_clockwise_bearing_angle_unit: PASS");
		else
			$display("tb_clockwise_bearing_angle_unit: FAIL");
		$finish;
	end

endmodule
